@@ design/rgbs_pkg.sv @@
// shared types and constants for the one-wire rgb led serializer
package rgbs_pkg;

	// input beat kinds carried on s_tuser
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_COLOR = 2'd1,
		MODE_SEND  = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ONE_HIGH  = 2'd0,
		CFG_ONE_LOW   = 2'd1,
		CFG_ZERO_HIGH = 2'd2,
		CFG_ZERO_LOW  = 2'd3
	} cfg_idx_t;

	localparam int TICK_COUNT_WIDTH = 6;
	localparam int CFG_REGS         = 4;
	localparam int CFG_IDX_W        = 2;

	// tick register reset values
	localparam int ONE_HIGH_RST  = 37;
	localparam int ONE_LOW_RST   = 21;
	localparam int ZERO_HIGH_RST = 18;
	localparam int ZERO_LOW_RST  = 40;

	// frame layout
	localparam int FRAME_BITS = 24;
	localparam int BITS_W     = 5;
	localparam int CHAN_W     = 8;
	localparam int OUT_DATA_W = 8;

	// one result item
	typedef struct packed {
		logic busy_res;
		logic line_level;
	} result_t;

endpackage

@@ design/rgbs_cfg.sv @@
// tick length registers written over the configuration channel
module rgbs_cfg #(
	parameter int TICK_COUNT_WIDTH = rgbs_pkg::TICK_COUNT_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  rgbs_pkg::cfg_idx_t                  wr_index,
	input  logic [TICK_COUNT_WIDTH-1:0]         wr_data,
	output logic [TICK_COUNT_WIDTH-1:0]         one_high,
	output logic [TICK_COUNT_WIDTH-1:0]         one_low,
	output logic [TICK_COUNT_WIDTH-1:0]         zero_high,
	output logic [TICK_COUNT_WIDTH-1:0]         zero_low
);

	logic [TICK_COUNT_WIDTH-1:0] one_high_q, one_low_q, zero_high_q, zero_low_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q  <= TICK_COUNT_WIDTH'(rgbs_pkg::ONE_HIGH_RST);
			one_low_q   <= TICK_COUNT_WIDTH'(rgbs_pkg::ONE_LOW_RST);
			zero_high_q <= TICK_COUNT_WIDTH'(rgbs_pkg::ZERO_HIGH_RST);
			zero_low_q  <= TICK_COUNT_WIDTH'(rgbs_pkg::ZERO_LOW_RST);
		end else if (wr_en) begin
			unique case (wr_index)
				rgbs_pkg::CFG_ONE_HIGH:  one_high_q  <= wr_data;
				rgbs_pkg::CFG_ONE_LOW:   one_low_q   <= wr_data;
				rgbs_pkg::CFG_ZERO_HIGH: zero_high_q <= wr_data;
				rgbs_pkg::CFG_ZERO_LOW:  zero_low_q  <= wr_data;
				default: ;
			endcase
		end
	end

	assign one_high  = one_high_q;
	assign one_low   = one_low_q;
	assign zero_high = zero_high_q;
	assign zero_low  = zero_low_q;

endmodule

@@ design/rgbs_enc.sv @@
// colour store, frame shifter and pulse-width phase counter
module rgbs_enc #(
	parameter int TICK_COUNT_WIDTH = rgbs_pkg::TICK_COUNT_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_en,
	input  rgbs_pkg::mode_t             mode,
	input  logic [rgbs_pkg::CHAN_W-1:0] red,
	input  logic [rgbs_pkg::CHAN_W-1:0] green,
	input  logic [rgbs_pkg::CHAN_W-1:0] blue,
	input  logic [TICK_COUNT_WIDTH-1:0] one_high,
	input  logic [TICK_COUNT_WIDTH-1:0] one_low,
	input  logic [TICK_COUNT_WIDTH-1:0] zero_high,
	input  logic [TICK_COUNT_WIDTH-1:0] zero_low,
	output rgbs_pkg::result_t           result
);

	localparam int FB = rgbs_pkg::FRAME_BITS;
	localparam int BW = rgbs_pkg::BITS_W;
	localparam int CW = rgbs_pkg::CHAN_W;
	localparam int TW = TICK_COUNT_WIDTH;

	logic [CW-1:0] red_q, green_q, blue_q;
	logic          pending_q, sending_q, high_q;
	logic [FB-1:0] shift_q;
	logic [BW-1:0] bits_q;
	logic [TW-1:0] phase_q;

	logic [CW-1:0] red_d, green_d, blue_d;
	logic          pending_d, sending_d, high_d;
	logic [FB-1:0] shift_d, word;
	logic [BW-1:0] bits_d;
	logic [TW-1:0] phase_d;

	// a zero tick count behaves as one tick
	function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] v);
		return (v == '0) ? TW'(1) : v;
	endfunction

	assign word = {green_q, red_q, blue_q};

	// next state for the accepted beat
	always_comb begin
		red_d     = red_q;
		green_d   = green_q;
		blue_d    = blue_q;
		pending_d = pending_q;
		sending_d = sending_q;
		high_d    = high_q;
		shift_d   = shift_q;
		bits_d    = bits_q;
		phase_d   = phase_q;
		unique case (mode)
			rgbs_pkg::MODE_COLOR: begin
				red_d     = red;
				green_d   = green;
				blue_d    = blue;
				pending_d = 1'b1;
			end
			rgbs_pkg::MODE_SEND: begin
				if (pending_q && !sending_q) begin
					shift_d   = word;
					bits_d    = BW'(FB);
					sending_d = 1'b1;
					pending_d = 1'b0;
					high_d    = 1'b1;
					phase_d   = at_least_one(word[FB-1] ? one_high : zero_high);
				end
			end
			rgbs_pkg::MODE_TICK: begin
				if (sending_q) begin
					if (phase_q <= TW'(1)) begin
						if (high_q) begin
							// high part done, start the low part of the same bit
							high_d  = 1'b0;
							phase_d = at_least_one(shift_q[FB-1] ? one_low : zero_low);
						end else begin
							// bit done, move to the next one
							shift_d = {shift_q[FB-2:0], 1'b0};
							bits_d  = bits_q - BW'(1);
							if (bits_q == BW'(1)) begin
								sending_d = 1'b0;
								high_d    = 1'b0;
								phase_d   = '0;
							end else begin
								high_d  = 1'b1;
								phase_d = at_least_one(shift_q[FB-2] ? one_high : zero_high);
							end
						end
					end else begin
						phase_d = phase_q - TW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// control, shift and colour state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b1;
			sending_q <= 1'b0;
			high_q    <= 1'b0;
			bits_q    <= '0;
			phase_q   <= '0;
			shift_q   <= '0;
			red_q     <= '0;
			green_q   <= '0;
			blue_q    <= '0;
		end else if (in_en) begin
			pending_q <= pending_d;
			sending_q <= sending_d;
			high_q    <= high_d;
			bits_q    <= bits_d;
			phase_q   <= phase_d;
			shift_q   <= shift_d;
			red_q     <= red_d;
			green_q   <= green_d;
			blue_q    <= blue_d;
		end
	end

	// result reflects the state after this beat
	assign result.line_level = sending_d && high_d;
	assign result.busy_res   = sending_d;

endmodule

@@ design/rgbs_obuf.sv @@
// two-entry output register with skid slot
module rgbs_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rgbs_pkg::result_t push_data,
	output logic              push_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rgbs_pkg::result_t out_data
);

	rgbs_pkg::result_t head_q, skid_q;
	logic              head_v_q, skid_v_q;
	logic              pop;

	assign pop = head_v_q && out_ready;

	// head and skid slot update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!head_v_q || pop) begin
				head_v_q <= skid_v_q || push;
				skid_v_q <= skid_v_q && push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (!head_v_q || pop) begin
			head_q <= skid_v_q ? skid_q : push_data;
			if (skid_v_q && push) begin
				skid_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign push_ready = !skid_v_q;
	assign out_valid  = head_v_q;
	assign out_data   = head_q;

endmodule

@@ design/rgb_led_one_wire_serializer_core.sv @@
// top level of the one-wire rgb led serializer
//
// channel  | direction | handshake          | payload
// s_       | in        | s_tvalid/s_tready  | s_tuser mode, s_tdata red/green/blue
// m_       | out       | m_tvalid/m_tready  | m_tdata line_level, busy_res
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data tick length
//
// one input beat per clock while s_tready is high; its result is registered in the output buffer
// the state update is a single pass through the encoder between state and output regs
// a two-entry output buffer keeps input open for one beat while the output stalls
// reset loads default tick lengths, clears the colour and marks a frame pending
// cfg_ready is always high
module rgb_led_one_wire_serializer_core #(
	parameter int TICK_COUNT_WIDTH = rgbs_pkg::TICK_COUNT_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [3*rgbs_pkg::CHAN_W-1:0]        s_tdata,   // red, green, blue
	input  logic [1:0]                           s_tuser,   // mode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [rgbs_pkg::OUT_DATA_W-1:0]      m_tdata,   // line_level, busy_res, zeros
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rgbs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [TICK_COUNT_WIDTH-1:0]          cfg_data
);

	localparam int CW = rgbs_pkg::CHAN_W;

	logic                        s_beat;
	logic [TICK_COUNT_WIDTH-1:0] one_high, one_low, zero_high, zero_low;
	rgbs_pkg::result_t           enc_res, out_res;

	assign s_beat    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// tick length registers
	rgbs_cfg #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid),
		.wr_index  (rgbs_pkg::cfg_idx_t'(cfg_index)),
		.wr_data   (cfg_data),
		.one_high  (one_high),
		.one_low   (one_low),
		.zero_high (zero_high),
		.zero_low  (zero_low)
	);

	// encoder state
	rgbs_enc #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_en     (s_beat),
		.mode      (rgbs_pkg::mode_t'(s_tuser)),
		.red       (s_tdata[CW-1:0]),
		.green     (s_tdata[2*CW-1:CW]),
		.blue      (s_tdata[3*CW-1:2*CW]),
		.one_high  (one_high),
		.one_low   (one_low),
		.zero_high (zero_high),
		.zero_low  (zero_low),
		.result    (enc_res)
	);

	// output register
	rgbs_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_beat),
		.push_data  (enc_res),
		.push_ready (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_res)
	);

	assign m_tdata = {{(rgbs_pkg::OUT_DATA_W-2){1'b0}}, out_res.busy_res, out_res.line_level};

`ifndef SYNTHESIS
	// every accepted beat leaves a result waiting
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> m_tvalid)
		else $error("no result after accepted beat");

	// input stalls only while the output holds a full buffer
	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// the line is only driven high during a frame
	a_high_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("line high while idle");
`endif

endmodule
